// ----- rtl/rmv_pkg.sv -----
// ----------------------------------------------------------------------------
// rmv_pkg: shared widths for the running mean and variance block
// Sample, count, mean and sum-of-squares widths, plus derived datapath sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package rmv_pkg;

  // input and state sizes
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 32;
  localparam int MEAN_W      = 40;
  localparam int M2_W        = 64;
  localparam int OUT_CNT_W   = 32;
  localparam int VAR_W       = 32;
  localparam int FRAC_SHIFT  = 16;  // Q.8 sample to Q.24 mean
  localparam int PROD_SHIFT  = 32;  // Q.48 product to Q.16 sum

  // delta = x24 - mean, one bit wider than the wider operand
  localparam int X24_W   = SAMPLE_BITS + FRAC_SHIFT;
  localparam int DELTA_W = ((X24_W > MEAN_W) ? X24_W : MEAN_W) + 1;

  // multiplier split: two halves, lower half the wider one
  localparam int MUL_LO    = (DELTA_W + 1) / 2;
  localparam int MUL_HI    = DELTA_W - MUL_LO;
  localparam int PP_W      = 2 * MUL_LO;
  localparam int ACC_W     = 2 * DELTA_W;
  localparam int MUL_STEPS = 4;

  // divider step counter
  localparam int DIV_CNT_W = $clog2(DELTA_W + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [OUT_CNT_W-1:0]  OUT_CNT_MAX = {OUT_CNT_W{1'b1}};
  localparam logic [VAR_W-1:0]      VAR_MAX     = {VAR_W{1'b1}};
  localparam logic [M2_W-1:0]       M2_MAX      = {M2_W{1'b1}};
  localparam logic [MEAN_W-1:0]     MEAN_MAX    = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic [MEAN_W-1:0]     MEAN_MIN    = {1'b1, {(MEAN_W-1){1'b0}}};

endpackage : rmv_pkg

`default_nettype wire

// ----- rtl/rmv_ifs.sv -----
// ----------------------------------------------------------------------------
// rmv_ifs: valid/ready channels of the running mean and variance block
// Sample request channel and statistics result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmv_in_if;
  import rmv_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface : rmv_in_if

interface rmv_out_if;
  import rmv_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OUT_CNT_W-1:0]     sample_count;
  logic signed [MEAN_W-1:0] mean_value;
  logic [VAR_W-1:0]         variance_value;
  logic                     variance_valid;

  modport source (output valid, output sample_count, output mean_value,
                  output variance_value, output variance_valid, input ready);
  modport sink   (input valid, input sample_count, input mean_value,
                  input variance_value, input variance_valid, output ready);
endinterface : rmv_out_if

`default_nettype wire

// ----- rtl/running_mean_variance.sv -----
// ----------------------------------------------------------------------------
// running_mean_variance: online mean and sample variance
// Welford update of count, mean (Q15.24) and M2 (Q48.16) per sample, and
// the sample variance M2/(n-1) in Q16.16, using one shared radix-2 divider
// and one narrow multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                                      handshake
//  in_chan   sink       sample (s16, Q7.8)                           valid/ready
//  out_chan  source     sample_count, mean_value, variance_value,    valid/ready
//                       variance_valid
//
//  per sample the sequencer runs the delta/n division, the mean update,
//  the multiplier, the M2 update, the variance load and the M2/(n-1)
//  division; the first sample and a saturated variance skip the
//  second division. reset is synchronous, active low, and clears count,
//  mean and M2. a new request is taken once the sequencer is idle, even while
//  the previous result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module running_mean_variance (
  input  wire           clk,
  input  wire           rst_n,
  rmv_in_if.sink        in_chan,
  rmv_out_if.source     out_chan
);
  import rmv_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_MEAN,
    ST_MEAN,
    ST_MUL,
    ST_M2,
    ST_VAR_LOAD,
    ST_DIV_VAR,
    ST_DONE
  } state_t;

  state_t                     state_r;

  // statistics state
  logic [COUNT_BITS-1:0]      count_r;
  logic [MEAN_W-1:0]          mean_r;
  logic [M2_W-1:0]            m2_r;

  // per-sample working registers
  logic [DELTA_W-1:0]         x24_r;
  logic [DELTA_W-1:0]         delta_r;
  logic [DELTA_W-1:0]         mul_a_r;
  logic [DELTA_W-1:0]         mul_b_r;
  logic                       neg_r;
  logic [PP_W-1:0]            mul_p_r;
  logic [ACC_W-1:0]           acc_r;
  logic [2:0]                 mul_cnt_r;

  // shared divider
  logic [COUNT_BITS-1:0]      div_d_r;
  logic [COUNT_BITS-1:0]      div_rem_r;
  logic [DELTA_W-1:0]         div_quo_r;
  logic [DIV_CNT_W-1:0]       div_cnt_r;

  // result registers
  logic                       out_valid_r;
  logic [OUT_CNT_W-1:0]       out_cnt_r;
  logic [MEAN_W-1:0]          out_mean_r;
  logic [VAR_W-1:0]           out_var_r;
  logic                       out_vvalid_r;
  logic [VAR_W-1:0]           var_r;
  logic                       vvalid_r;

  logic                       in_accept;
  logic                       out_free;

  logic [COUNT_BITS-1:0]      count_nxt;
  logic [DELTA_W-1:0]         x24_nxt;
  logic [DELTA_W-1:0]         mean_ext;
  logic [DELTA_W-1:0]         delta_nxt;

  logic [COUNT_BITS+1:0]      div_trial;
  logic                       div_borrow;
  logic [COUNT_BITS-1:0]      div_rem_nxt;
  logic [DELTA_W-1:0]         div_quo_nxt;

  logic [DELTA_W:0]           q_signed;
  logic [DELTA_W:0]           nm_wide;
  logic                       nm_ovf;
  logic [MEAN_W-1:0]          mean_nxt;
  logic [DELTA_W-1:0]         dev2;
  logic [DELTA_W-1:0]         abs_delta;
  logic [DELTA_W-1:0]         abs_dev2;

  logic [MUL_LO-1:0]          a_lo, b_lo, a_hi, b_hi;
  logic [MUL_LO-1:0]          mul_x, mul_y;
  logic [1:0]                 pp_idx;
  logic [1:0]                 acc_idx;
  logic [ACC_W-1:0]           pp_shifted;

  logic [ACC_W-1:0]           prod_ext;
  logic [M2_W-1:0]            prod;
  logic [M2_W:0]              m2_sum;
  logic [M2_W-1:0]            m2_nxt;

  logic [COUNT_BITS-1:0]      var_div;
  logic                       var_sat;
  logic [OUT_CNT_W-1:0]       cnt_out;

  // handshake
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_accept     = in_chan.valid && (state_r == ST_IDLE);
  assign out_free      = !out_valid_r || out_chan.ready;

  assign out_chan.valid          = out_valid_r;
  assign out_chan.sample_count   = out_cnt_r;
  assign out_chan.mean_value     = out_mean_r;
  assign out_chan.variance_value = out_var_r;
  assign out_chan.variance_valid = out_vvalid_r;

  // count, scaled sample and delta at request time
  assign count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + COUNT_BITS'(1);
  assign x24_nxt   = {{(DELTA_W-SAMPLE_BITS-FRAC_SHIFT){in_chan.sample[SAMPLE_BITS-1]}},
                      in_chan.sample, {FRAC_SHIFT{1'b0}}};
  assign mean_ext  = {{(DELTA_W-MEAN_W){mean_r[MEAN_W-1]}}, mean_r};
  assign delta_nxt = x24_nxt - mean_ext;

  // one restoring divider step
  assign div_trial   = {1'b0, div_rem_r, div_quo_r[DELTA_W-1]} - {2'b00, div_d_r};
  assign div_borrow  = div_trial[COUNT_BITS+1];
  assign div_rem_nxt = div_borrow ? {div_rem_r[COUNT_BITS-2:0], div_quo_r[DELTA_W-1]}
                                  : div_trial[COUNT_BITS-1:0];
  assign div_quo_nxt = {div_quo_r[DELTA_W-2:0], !div_borrow};

  // new mean: old mean plus signed quotient, clamped to the Q15.24 range
  assign abs_delta = delta_r[DELTA_W-1] ? (~delta_r + DELTA_W'(1)) : delta_r;
  assign q_signed  = delta_r[DELTA_W-1] ? (~{1'b0, div_quo_r} + (DELTA_W+1)'(1))
                                        : {1'b0, div_quo_r};
  assign nm_wide   = {mean_ext[DELTA_W-1], mean_ext} + q_signed;
  assign nm_ovf    = !((&nm_wide[DELTA_W:MEAN_W-1]) || !(|nm_wide[DELTA_W:MEAN_W-1]));
  assign mean_nxt  = nm_ovf ? (nm_wide[DELTA_W] ? MEAN_MIN : MEAN_MAX)
                            : nm_wide[MEAN_W-1:0];
  assign dev2      = x24_r - {{(DELTA_W-MEAN_W){mean_nxt[MEAN_W-1]}}, mean_nxt};
  assign abs_dev2  = dev2[DELTA_W-1] ? (~dev2 + DELTA_W'(1)) : dev2;

  // partial product operands: lo*lo, lo*hi, hi*lo, hi*hi
  assign a_lo   = mul_a_r[MUL_LO-1:0];
  assign b_lo   = mul_b_r[MUL_LO-1:0];
  assign a_hi   = MUL_LO'(mul_a_r[DELTA_W-1:MUL_LO]);
  assign b_hi   = MUL_LO'(mul_b_r[DELTA_W-1:MUL_LO]);
  assign pp_idx = mul_cnt_r[1:0];
  assign mul_x  = pp_idx[1] ? a_hi : a_lo;
  assign mul_y  = pp_idx[0] ? b_hi : b_lo;

  // alignment of the previous partial product
  assign acc_idx = pp_idx - 2'd1;
  always_comb begin
    unique case (acc_idx)
      2'd0:    pp_shifted = ACC_W'(mul_p_r);
      2'd3:    pp_shifted = ACC_W'(mul_p_r) << (2 * MUL_LO);
      default: pp_shifted = ACC_W'(mul_p_r) << MUL_LO;
    endcase
  end

  // M2 update with floor at zero and saturation at the top
  assign prod_ext = acc_r >> PROD_SHIFT;
  assign prod     = ((prod_ext >> M2_W) != '0) ? M2_MAX : prod_ext[M2_W-1:0];
  assign m2_sum   = {1'b0, m2_r} + {1'b0, prod};
  always_comb begin
    if (neg_r) begin
      m2_nxt = (m2_r > prod) ? (m2_r - prod) : '0;
    end else begin
      m2_nxt = m2_sum[M2_W] ? M2_MAX : m2_sum[M2_W-1:0];
    end
  end

  // variance: quotient of 2^32 or more saturates, else 32 quotient bits
  assign var_div = count_r - COUNT_BITS'(1);
  assign var_sat = (M2_W'(m2_r >> VAR_W)) >= M2_W'(var_div);

  assign cnt_out = (M2_W'(count_r) > M2_W'(OUT_CNT_MAX)) ? OUT_CNT_MAX
                                                          : OUT_CNT_W'(count_r);

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      mean_r      <= '0;
      m2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            count_r   <= count_nxt;
            x24_r     <= x24_nxt;
            delta_r   <= delta_nxt;
            div_d_r   <= count_nxt;
            div_rem_r <= '0;
            div_quo_r <= delta_nxt[DELTA_W-1] ? (~delta_nxt + DELTA_W'(1)) : delta_nxt;
            div_cnt_r <= DIV_CNT_W'(DELTA_W);
            state_r   <= ST_DIV_MEAN;
          end
        end
        ST_DIV_MEAN: begin
          div_rem_r <= div_rem_nxt;
          div_quo_r <= div_quo_nxt;
          div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
          if (div_cnt_r == DIV_CNT_W'(1)) begin
            state_r <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          mean_r    <= mean_nxt;
          mul_a_r   <= abs_delta;
          mul_b_r   <= abs_dev2;
          neg_r     <= delta_r[DELTA_W-1] != dev2[DELTA_W-1];
          acc_r     <= '0;
          mul_cnt_r <= '0;
          state_r   <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_cnt_r != 3'(MUL_STEPS)) begin
            mul_p_r <= PP_W'(mul_x) * PP_W'(mul_y);
          end
          if (mul_cnt_r != 3'd0) begin
            acc_r <= acc_r + pp_shifted;
          end
          mul_cnt_r <= mul_cnt_r + 3'd1;
          if (mul_cnt_r == 3'(MUL_STEPS)) begin
            state_r <= ST_M2;
          end
        end
        ST_M2: begin
          m2_r <= m2_nxt;
          if (count_r >= COUNT_BITS'(2)) begin
            state_r <= ST_VAR_LOAD;
          end else begin
            var_r    <= '0;
            vvalid_r <= 1'b0;
            state_r  <= ST_DONE;
          end
        end
        ST_VAR_LOAD: begin
          vvalid_r <= 1'b1;
          if (var_sat) begin
            var_r   <= VAR_MAX;
            state_r <= ST_DONE;
          end else begin
            div_d_r   <= var_div;
            div_rem_r <= COUNT_BITS'(m2_r >> VAR_W);
            div_quo_r <= DELTA_W'(m2_r[VAR_W-1:0]) << (DELTA_W - VAR_W);
            div_cnt_r <= DIV_CNT_W'(VAR_W);
            state_r   <= ST_DIV_VAR;
          end
        end
        ST_DIV_VAR: begin
          div_rem_r <= div_rem_nxt;
          div_quo_r <= div_quo_nxt;
          div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
          if (div_cnt_r == DIV_CNT_W'(1)) begin
            var_r   <= div_quo_nxt[VAR_W-1:0];
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_cnt_r    <= cnt_out;
            out_mean_r   <= mean_r;
            out_var_r    <= var_r;
            out_vvalid_r <= vvalid_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // a request keeps the sequencer busy on the next cycle
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_chan.ready)
    else $error("request taken while sequencer busy");

  // the variance division only runs with two or more samples
  a_var_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_VAR) |-> (count_r >= COUNT_BITS'(2)))
    else $error("variance division with fewer than two samples");

  // a flagged variance needs at least two samples, an unflagged one is zero
  a_vvalid_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_vvalid_r == (out_cnt_r >= OUT_CNT_W'(2))))
    else $error("variance flag disagrees with sample count");

  a_vzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_vvalid_r) |-> (out_var_r == '0))
    else $error("variance not zero while flag clear");

  // M2 only changes in its update step
  a_m2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_M2) |=> $stable(m2_r))
    else $error("M2 changed outside its update step");

endmodule : running_mean_variance

`default_nettype wire

// ----- dv/rmv_stats_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmv_stats_checker: result scoreboard for the running mean and variance block
// Watches the sample and result channels, keeps its own Welford statistics
// for every accepted request and compares each result field by field, in
// order, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module rmv_stats_checker (
  input  logic clk,
  input  logic rst_n,
  rmv_in_if    in_chan,
  rmv_out_if   out_chan,
  output int   mismatch_total,
  output int   outstanding
);
  import rmv_pkg::*;

  typedef struct packed {
    logic [OUT_CNT_W-1:0]     sample_count;
    logic signed [MEAN_W-1:0] mean_value;
    logic [VAR_W-1:0]         variance_value;
    logic                     variance_valid;
  } stats_t;

  // running statistics as the block should hold them
  logic [COUNT_BITS-1:0]    n_seen;
  logic signed [MEAN_W-1:0] mean_q24;
  logic [M2_W-1:0]          m2_q16;

  stats_t pending_stats[$];

  assign outstanding = pending_stats.size();

  // one Welford step: fold the sample in and return the reported statistics
  function automatic stats_t welford_update(logic signed [SAMPLE_BITS-1:0] x);
    longint          x24;
    longint          delta;
    longint          step;
    longint          new_mean;
    longint          dev2;
    logic [127:0]    mag_delta;
    logic [127:0]    mag_dev2;
    logic [127:0]    prod_wide;
    logic [M2_W-1:0] prod_q16;
    logic [63:0]     n_wide;
    logic [M2_W-1:0] var_wide;
    stats_t          r;

    x24 = longint'(x) * (longint'(1) << FRAC_SHIFT);
    if (n_seen != COUNT_MAX) n_seen = n_seen + 1'b1;
    n_wide = 64'(n_seen);

    // mean moves by delta/n, truncated toward zero, clamped to Q15.24
    delta    = x24 - longint'(mean_q24);
    step     = delta / longint'(n_wide);
    new_mean = longint'(mean_q24) + step;
    if (new_mean > longint'(MEAN_MAX)) new_mean = longint'(MEAN_MAX);
    if (new_mean < longint'($signed(MEAN_MIN))) new_mean = longint'($signed(MEAN_MIN));
    mean_q24 = new_mean[MEAN_W-1:0];

    // M2 gains delta * (x - new mean), Q.48 brought down to Q.16
    dev2      = x24 - new_mean;
    mag_delta = (delta < 0) ? 128'(-delta) : 128'(delta);
    mag_dev2  = (dev2 < 0) ? 128'(-dev2) : 128'(dev2);
    prod_wide = (mag_delta * mag_dev2) >> PROD_SHIFT;
    prod_q16  = (|prod_wide[127:M2_W]) ? M2_MAX : prod_wide[M2_W-1:0];
    if ((delta < 0) != (dev2 < 0)) begin
      m2_q16 = (m2_q16 > prod_q16) ? m2_q16 - prod_q16 : '0;
    end else begin
      m2_q16 = (M2_MAX - m2_q16 < prod_q16) ? M2_MAX : m2_q16 + prod_q16;
    end

    r.sample_count = (n_wide > 64'(OUT_CNT_MAX)) ? OUT_CNT_MAX : n_wide[OUT_CNT_W-1:0];
    r.mean_value   = mean_q24;
    if (n_wide >= 64'd2) begin
      var_wide         = m2_q16 / (n_wide - 64'd1);
      r.variance_value = (var_wide > 64'(VAR_MAX)) ? VAR_MAX : var_wide[VAR_W-1:0];
      r.variance_valid = 1'b1;
    end else begin
      // a lone sample has no sample variance
      r.variance_value = '0;
      r.variance_valid = 1'b0;
    end
    return r;
  endfunction

  task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatch_total++;
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, field, want, got);
    end
  endtask

  // results are checked before the same-edge request is folded in
  always @(posedge clk) begin
    stats_t want;
    if (!rst_n) begin
      n_seen         = '0;
      mean_q24       = '0;
      m2_q16         = '0;
      mismatch_total = 0;
      pending_stats.delete();
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (pending_stats.size() == 0) begin
          mismatch_total++;
          $display("%0t: result expected none got count 0x%0h", $time,
                   out_chan.sample_count);
        end else begin
          want = pending_stats.pop_front();
          report_field("sample_count", 64'(want.sample_count), 64'(out_chan.sample_count));
          report_field("mean_value", 64'(want.mean_value), 64'(out_chan.mean_value));
          report_field("variance_value", 64'(want.variance_value),
                       64'(out_chan.variance_value));
          report_field("variance_valid", 64'(want.variance_valid),
                       64'(out_chan.variance_valid));
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        pending_stats.insert(pending_stats.size(), welford_update(in_chan.sample));
      end
    end
  end

endmodule : rmv_stats_checker

// ----- dv/tb_running_mean_variance.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_running_mean_variance: testbench for the running mean and variance block
// Drives a directed run of extreme and patterned samples, then segments of
// random, clustered, constant and extreme samples with random request gaps
// and result back-pressure; the checker scores every result.
// ----------------------------------------------------------------------------

module tb_running_mean_variance;
  import rmv_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT  = 600000;

  typedef enum int {SEG_UNIFORM, SEG_CLUSTER, SEG_CONSTANT, SEG_EXTREME} seg_kind_e;

  logic clk;
  logic rst_n;
  int   mismatch_total;
  int   outstanding;
  int   cycle_count = 0;
  bit   sender_quiet;

  rmv_in_if  in_chan ();
  rmv_out_if out_chan ();

  running_mean_variance dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  rmv_stats_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_chan        (in_chan),
    .out_chan       (out_chan),
    .mismatch_total (mismatch_total),
    .outstanding    (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("running_mean_variance: mismatch");
      $finish;
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[SAMPLE_BITS-1:0];
  endfunction

  // one sample request, after a random gap unless in a quiet stretch
  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] v);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.sample <= v;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // result side: refuse a random number of valid cycles per result
  initial begin
    int stall;
    int taken;
    bit quiet;
    out_chan.ready <= 1'b0;
    taken = 0;
    quiet = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (taken % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      stall = quiet ? 0 : $urandom_range(0, 3);
      out_chan.ready <= (stall == 0);
      @(posedge clk);
      while (!(out_chan.valid && out_chan.ready)) begin
        if (out_chan.valid && stall > 0) stall--;
        out_chan.ready <= (stall == 0);
        @(posedge clk);
      end
      taken++;
    end
  end

  // stimulus and verdict
  initial begin
    logic signed [SAMPLE_BITS-1:0] directed[$];
    seg_kind_e kind;
    int seg_len;
    int sent;
    int centre;
    int spread;
    int v;

    in_chan.valid  <= 1'b0;
    in_chan.sample <= '0;
    rst_n          <= 1'b0;
    sender_quiet   = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // first sample, full-scale swings, small values and bit patterns
    directed = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
                 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh5555,
                 16'shaaaa, 16'sh0100, 16'shff00, 16'sh7f00, 16'sh80ff,
                 16'sh0000, 16'sh0000, 16'sh7fff, 16'sh8000, 16'sh1234};
    foreach (directed[i]) send_sample(directed[i]);

    // random segments of differently shaped sample streams
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind         = seg_kind_e'($urandom_range(0, 3));
      seg_len      = $urandom_range(20, 100);
      sender_quiet = ($urandom_range(0, 3) == 0);
      centre       = int'($urandom_range(0, 65535)) - 32768;
      spread       = 1 << $urandom_range(0, 10);
      for (int i = 0; i < seg_len && sent < RANDOM_ITEMS; i++) begin
        case (kind)
          SEG_UNIFORM:  v = int'($urandom_range(0, 65535)) - 32768;
          SEG_CLUSTER:  v = centre + int'($urandom_range(0, 2 * spread)) - spread;
          SEG_CONSTANT: v = centre;
          default:      v = $urandom_range(0, 1) ? 32767 : -32768;
        endcase
        send_sample(clamp_sample(v));
        sent++;
      end
    end
    in_chan.valid <= 1'b0;

    // drain, then allow for any late stray result
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_total == 0 && outstanding == 0) begin
      $display("running_mean_variance: match");
    end else begin
      $display("running_mean_variance: mismatch");
    end
    $finish;
  end

endmodule : tb_running_mean_variance
